// ===== rtl/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, hue sector codes and the control word that travels with
// each pixel through the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HUE_W    = 20;
  localparam int LEVEL_W  = 18;
  localparam int CHAN_W   = 17;
  localparam int SECTOR_W = 3;

  // Hue sectors, one sixth of a turn each
  localparam logic [SECTOR_W-1:0] SEC_RY = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_YG = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_GC = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_CB = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_BM = 3'd4;
  localparam logic [SECTOR_W-1:0] SEC_MR = 3'd5;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic                early;   // black or grey pixel, alpha not written
  } hsvrgb_ctl_t;

endpackage

// ===== rtl/hsvrgb_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_in_if
// Pixel input channel: hue, brightness, saturation and alpha.
// ----------------------------------------------------------------------------
interface hsvrgb_in_if;
  import hsvrgb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [HUE_W-1:0]   hue;
  logic signed [LEVEL_W-1:0] brightness;
  logic signed [LEVEL_W-1:0] saturation;
  logic [CHAN_W-1:0]         alpha;

  modport source (output valid, hue, brightness, saturation, alpha, input ready);
  modport sink   (input valid, hue, brightness, saturation, alpha, output ready);
endinterface

// ===== rtl/hsvrgb_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_out_if
// Pixel result channel: red, green, blue, alpha and the alpha write flag.
// ----------------------------------------------------------------------------
interface hsvrgb_out_if;
  import hsvrgb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha_out;
  logic              alpha_written;

  modport source (output valid, red, green, blue, alpha_out, alpha_written, input ready);
  modport sink   (input valid, red, green, blue, alpha_out, alpha_written, output ready);
endinterface

// ===== rtl/hsvrgb_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_prep
// First stage: wrap hue, split it into sector and fraction, clamp brightness
// and saturation and flag black or grey pixels.
// ----------------------------------------------------------------------------
module hsvrgb_prep #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hsvrgb_in_if.sink                  in_pix,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [FRACTION_BITS:0]     v_o,
  output logic [FRACTION_BITS:0]     s_o,
  output logic [FRACTION_BITS-1:0]   f_o,
  output hsvrgb_pkg::hsvrgb_ctl_t    ctl_o,
  output logic [hsvrgb_pkg::CHAN_W-1:0] alpha_o
);
  import hsvrgb_pkg::*;

  localparam int VW    = FRACTION_BITS + 1;
  localparam int XW    = FRACTION_BITS + 3;
  localparam int EXT_W = (FRACTION_BITS > HUE_W) ? FRACTION_BITS : HUE_W;
  localparam int CW    = (LEVEL_W > FRACTION_BITS + 2) ? LEVEL_W : FRACTION_BITS + 2;
  localparam logic signed [CW-1:0] ONE_C = CW'(64'sd1 << FRACTION_BITS);
  localparam logic [VW-1:0] ONE = VW'(1) << FRACTION_BITS;

  logic signed [EXT_W-1:0] hue_ext;
  logic [FRACTION_BITS-1:0] h;
  logic [XW-1:0]           x;
  logic signed [CW-1:0]    bri_ext;
  logic signed [CW-1:0]    sat_ext;
  logic [VW-1:0]           v_c;
  logic [VW-1:0]           sat_c;
  logic [VW-1:0]           s_c;
  logic                    valid_r;
  logic [VW-1:0]           v_r;
  logic [VW-1:0]           s_r;
  logic [FRACTION_BITS-1:0] f_r;
  hsvrgb_ctl_t             ctl_r;
  logic [CHAN_W-1:0]       alpha_r;
  logic                    load;

  always_comb begin
    hue_ext = EXT_W'(in_pix.hue);
    h       = hue_ext[FRACTION_BITS-1:0];
    x       = (XW'(h) << 2) + (XW'(h) << 1);

    bri_ext = CW'(in_pix.brightness);
    if (bri_ext < 0) begin
      v_c = '0;
    end else if (bri_ext > ONE_C) begin
      v_c = ONE;
    end else begin
      v_c = bri_ext[VW-1:0];
    end

    sat_ext = CW'(in_pix.saturation);
    if (sat_ext < 0) begin
      sat_c = '0;
    end else if (sat_ext > ONE_C) begin
      sat_c = ONE;
    end else begin
      sat_c = sat_ext[VW-1:0];
    end
    s_c = ONE - sat_c;
  end

  assign in_pix.ready = !valid_r || ready_i;
  assign load         = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_pix.ready) begin
      valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v_r          <= v_c;
      s_r          <= s_c;
      f_r          <= x[FRACTION_BITS-1:0];
      ctl_r.sector <= x[XW-1:FRACTION_BITS];
      ctl_r.early  <= (v_c == '0) || (s_c == '0);
      alpha_r      <= in_pix.alpha;
    end
  end

  assign valid_o = valid_r;
  assign v_o     = v_r;
  assign s_o     = s_r;
  assign f_o     = f_r;
  assign ctl_o   = ctl_r;
  assign alpha_o = alpha_r;
endmodule

// ===== rtl/hsvrgb_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_scale
// Two multiplier stages: saturation products and p, then q and t.
// ----------------------------------------------------------------------------
module hsvrgb_scale #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [FRACTION_BITS:0]        v_i,
  input  logic [FRACTION_BITS:0]        s_i,
  input  logic [FRACTION_BITS-1:0]      f_i,
  input  hsvrgb_pkg::hsvrgb_ctl_t       ctl_i,
  input  logic [hsvrgb_pkg::CHAN_W-1:0] alpha_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [FRACTION_BITS:0]        v_o,
  output logic [FRACTION_BITS:0]        p_o,
  output logic [FRACTION_BITS:0]        q_o,
  output logic [FRACTION_BITS:0]        t_o,
  output hsvrgb_pkg::hsvrgb_ctl_t       ctl_o,
  output logic [hsvrgb_pkg::CHAN_W-1:0] alpha_o
);
  import hsvrgb_pkg::*;

  localparam int VW = FRACTION_BITS + 1;
  localparam int PW = 2 * FRACTION_BITS + 2;
  localparam logic [VW-1:0] ONE = VW'(1) << FRACTION_BITS;

  logic [VW-1:0] one_f;
  logic [PW-1:0] prod_sf;
  logic [PW-1:0] prod_st;
  logic [PW-1:0] prod_p;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] prod_t;

  logic              valid2_r;
  logic              ready2;
  logic [VW-1:0]     v2_r;
  logic [VW-1:0]     ms_r;
  logic [VW-1:0]     mt_r;
  logic [VW-1:0]     p2_r;
  hsvrgb_ctl_t       ctl2_r;
  logic [CHAN_W-1:0] alpha2_r;

  logic              valid3_r;
  logic [VW-1:0]     v3_r;
  logic [VW-1:0]     p3_r;
  logic [VW-1:0]     q3_r;
  logic [VW-1:0]     t3_r;
  hsvrgb_ctl_t       ctl3_r;
  logic [CHAN_W-1:0] alpha3_r;

  always_comb begin
    one_f   = ONE - VW'(f_i);
    prod_sf = PW'(s_i) * PW'(f_i);
    prod_st = PW'(s_i) * PW'(one_f);
    prod_p  = PW'(v_i) * PW'(ONE - s_i);
    prod_q  = PW'(v2_r) * PW'(ONE - ms_r);
    prod_t  = PW'(v2_r) * PW'(ONE - mt_r);
  end

  assign ready2  = !valid3_r || ready_i;
  assign ready_o = !valid2_r || ready2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else begin
      if (ready_o) begin
        valid2_r <= valid_i;
      end
      if (ready2) begin
        valid3_r <= valid2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      v2_r     <= v_i;
      ms_r     <= prod_sf[2*FRACTION_BITS:FRACTION_BITS];
      mt_r     <= prod_st[2*FRACTION_BITS:FRACTION_BITS];
      p2_r     <= prod_p[2*FRACTION_BITS:FRACTION_BITS];
      ctl2_r   <= ctl_i;
      alpha2_r <= alpha_i;
    end
    if (valid2_r && ready2) begin
      v3_r     <= v2_r;
      p3_r     <= p2_r;
      q3_r     <= prod_q[2*FRACTION_BITS:FRACTION_BITS];
      t3_r     <= prod_t[2*FRACTION_BITS:FRACTION_BITS];
      ctl3_r   <= ctl2_r;
      alpha3_r <= alpha2_r;
    end
  end

  assign valid_o = valid3_r;
  assign v_o     = v3_r;
  assign p_o     = p3_r;
  assign q_o     = q3_r;
  assign t_o     = t3_r;
  assign ctl_o   = ctl3_r;
  assign alpha_o = alpha3_r;
endmodule

// ===== rtl/hsvrgb_mux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_mux
// Output stage: route v, p, q and t to the channels by hue sector and
// register the result transaction.
// ----------------------------------------------------------------------------
module hsvrgb_mux #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [FRACTION_BITS:0]        v_i,
  input  logic [FRACTION_BITS:0]        p_i,
  input  logic [FRACTION_BITS:0]        q_i,
  input  logic [FRACTION_BITS:0]        t_i,
  input  hsvrgb_pkg::hsvrgb_ctl_t       ctl_i,
  input  logic [hsvrgb_pkg::CHAN_W-1:0] alpha_i,
  hsvrgb_out_if.source                  out_pix
);
  import hsvrgb_pkg::*;

  logic [CHAN_W-1:0] v_c;
  logic [CHAN_W-1:0] p_c;
  logic [CHAN_W-1:0] q_c;
  logic [CHAN_W-1:0] t_c;
  logic [CHAN_W-1:0] red_nxt;
  logic [CHAN_W-1:0] green_nxt;
  logic [CHAN_W-1:0] blue_nxt;
  logic [CHAN_W-1:0] alpha_nxt;
  logic              written_nxt;

  logic              valid_r;
  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;
  logic [CHAN_W-1:0] alpha_r;
  logic              written_r;

  always_comb begin
    v_c = CHAN_W'(v_i);
    p_c = CHAN_W'(p_i);
    q_c = CHAN_W'(q_i);
    t_c = CHAN_W'(t_i);
    case (ctl_i.sector)
      SEC_RY: begin
        red_nxt = v_c; green_nxt = t_c; blue_nxt = p_c;
      end
      SEC_YG: begin
        red_nxt = q_c; green_nxt = v_c; blue_nxt = p_c;
      end
      SEC_GC: begin
        red_nxt = p_c; green_nxt = v_c; blue_nxt = t_c;
      end
      SEC_CB: begin
        red_nxt = p_c; green_nxt = q_c; blue_nxt = v_c;
      end
      SEC_BM: begin
        red_nxt = t_c; green_nxt = p_c; blue_nxt = v_c;
      end
      default: begin
        red_nxt = v_c; green_nxt = p_c; blue_nxt = q_c;
      end
    endcase
    alpha_nxt   = alpha_i;
    written_nxt = 1'b1;
    // black or grey: all channels carry the level, alpha zeroed and not written
    if (ctl_i.early) begin
      red_nxt     = v_c;
      green_nxt   = v_c;
      blue_nxt    = v_c;
      alpha_nxt   = '0;
      written_nxt = 1'b0;
    end
  end

  assign ready_o = !valid_r || out_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
      alpha_r   <= alpha_nxt;
      written_r <= written_nxt;
    end
  end

  assign out_pix.valid         = valid_r;
  assign out_pix.red           = red_r;
  assign out_pix.green         = green_r;
  assign out_pix.blue          = blue_r;
  assign out_pix.alpha_out     = alpha_r;
  assign out_pix.alpha_written = written_r;
endmodule

// ===== rtl/hsv_to_rgb_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel
// Converts one hue/brightness/saturation pixel per clock to red, green and
// blue levels in unsigned fixed point, 1.0 = 2**FRACTION_BITS. The pipeline
// takes a new transaction every cycle unless stalled and passes it through
// its registered stages: clamp and sector split, saturation products and p,
// q and t products, then channel routing into the output register. Each
// stage has its own valid bit and advances while the stage after it is
// empty or moving, so back-pressure stalls the pipeline without losing or
// repeating a transaction. Black and grey pixels come out with all channels
// at the clamped brightness and alpha_written low.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel #(
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  hsvrgb_in_if.sink     in_pix,
  hsvrgb_out_if.source  out_pix
);
  import hsvrgb_pkg::*;

  logic                     s1_valid;
  logic                     s1_ready;
  logic [FRACTION_BITS:0]   s1_v;
  logic [FRACTION_BITS:0]   s1_s;
  logic [FRACTION_BITS-1:0] s1_f;
  hsvrgb_ctl_t              s1_ctl;
  logic [CHAN_W-1:0]        s1_alpha;

  logic                     s3_valid;
  logic                     s3_ready;
  logic [FRACTION_BITS:0]   s3_v;
  logic [FRACTION_BITS:0]   s3_p;
  logic [FRACTION_BITS:0]   s3_q;
  logic [FRACTION_BITS:0]   s3_t;
  hsvrgb_ctl_t              s3_ctl;
  logic [CHAN_W-1:0]        s3_alpha;

  hsvrgb_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .v_o     (s1_v),
    .s_o     (s1_s),
    .f_o     (s1_f),
    .ctl_o   (s1_ctl),
    .alpha_o (s1_alpha)
  );

  hsvrgb_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .v_i     (s1_v),
    .s_i     (s1_s),
    .f_i     (s1_f),
    .ctl_i   (s1_ctl),
    .alpha_i (s1_alpha),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .v_o     (s3_v),
    .p_o     (s3_p),
    .q_o     (s3_q),
    .t_o     (s3_t),
    .ctl_o   (s3_ctl),
    .alpha_o (s3_alpha)
  );

  hsvrgb_mux #(.FRACTION_BITS(FRACTION_BITS)) u_mux (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .v_i     (s3_v),
    .p_i     (s3_p),
    .q_i     (s3_q),
    .t_i     (s3_t),
    .ctl_i   (s3_ctl),
    .alpha_i (s3_alpha),
    .out_pix (out_pix)
  );
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hsv_to_rgb_pixel. Pixels go in through the input
// channel with random gaps and the results are taken with random
// back-pressure. A scoreboard class predicts each RGB result in fixed point
// from the accepted HSV pixel and compares it in order, field by field.
// Directed corner pixels come first, then random pixels in phases with and
// without gaps, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import hsvrgb_pkg::*;

  localparam int FRAC = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned FRAC_MASK = ONE - 1;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [HUE_W-1:0]   hue;
    logic signed [LEVEL_W-1:0] brightness;
    logic signed [LEVEL_W-1:0] saturation;
    logic [CHAN_W-1:0]         alpha;
  } pixel_hsv_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha_out;
    logic              alpha_written;
  } pixel_rgb_t;

  class hsv_scoreboard;
    pixel_rgb_t rgb_q[$];
    int mismatches = 0;
    int checked = 0;
    int black_cnt = 0;
    int grey_cnt = 0;
    int sector_cnt[6];

    function longint unsigned clamp_unit(longint signed x);
      if (x < 0) return 0;
      if (x > longint'(ONE)) return ONE;
      return unsigned'(x);
    endfunction

    function longint unsigned scale(longint unsigned a, longint unsigned b);
      return (a * b) >> FRAC;
    endfunction

    function pixel_rgb_t hsv_to_rgb(pixel_hsv_t px);
      longint signed hv;
      longint unsigned h, v, s, x, f, p, q, t, r, g, b;
      logic [SECTOR_W-1:0] sec;
      pixel_rgb_t res;
      hv = longint'($signed(px.hue));
      h = unsigned'(hv) & FRAC_MASK;
      v = clamp_unit(longint'($signed(px.brightness)));
      s = ONE - clamp_unit(longint'($signed(px.saturation)));
      if (v == 0 || s == 0) begin
        if (v == 0) black_cnt++;
        else grey_cnt++;
        res.red = v[CHAN_W-1:0];
        res.green = v[CHAN_W-1:0];
        res.blue = v[CHAN_W-1:0];
        res.alpha_out = '0;
        res.alpha_written = 1'b0;
        return res;
      end
      x = h * 6;
      sec = SECTOR_W'(x >> FRAC);
      f = x & FRAC_MASK;
      p = scale(v, ONE - s);
      q = scale(v, ONE - scale(s, f));
      t = scale(v, ONE - scale(s, ONE - f));
      sector_cnt[sec]++;
      case (sec)
        SEC_RY: begin r = v; g = t; b = p; end
        SEC_YG: begin r = q; g = v; b = p; end
        SEC_GC: begin r = p; g = v; b = t; end
        SEC_CB: begin r = p; g = q; b = v; end
        SEC_BM: begin r = t; g = p; b = v; end
        default: begin r = v; g = p; b = q; end
      endcase
      res.red = r[CHAN_W-1:0];
      res.green = g[CHAN_W-1:0];
      res.blue = b[CHAN_W-1:0];
      res.alpha_out = px.alpha;
      res.alpha_written = 1'b1;
      return res;
    endfunction

    function void note_pixel(pixel_hsv_t px);
      rgb_q.push_back(hsv_to_rgb(px));
    endfunction

    function void check_pixel(pixel_rgb_t got);
      pixel_rgb_t exp_rgb;
      if (rgb_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result r=%0d g=%0d b=%0d a=%0d w=%0b", $realtime,
                   got.red, got.green, got.blue, got.alpha_out, got.alpha_written);
        return;
      end
      exp_rgb = rgb_q.pop_front();
      checked++;
      if (got !== exp_rgb) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp r=%0d g=%0d b=%0d a=%0d w=%0b, got r=%0d g=%0d b=%0d a=%0d w=%0b",
                   $realtime, exp_rgb.red, exp_rgb.green, exp_rgb.blue, exp_rgb.alpha_out,
                   exp_rgb.alpha_written, got.red, got.green, got.blue, got.alpha_out,
                   got.alpha_written);
      end
    endfunction

    function int pending();
      return rgb_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_gaps;
  logic out_gaps;
  int   hold_left;
  hsv_scoreboard sb;

  hsvrgb_in_if  in_if();
  hsvrgb_out_if out_if();

  hsv_to_rgb_pixel #(
    .FRACTION_BITS(FRAC)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (in_if),
    .out_pix(out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // hold off or idle the result side at random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_if.ready <= !(out_gaps && $urandom_range(99) < 30);
    end
  end

  always @(posedge clk) begin
    pixel_rgb_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.red = out_if.red;
      got.green = out_if.green;
      got.blue = out_if.blue;
      got.alpha_out = out_if.alpha_out;
      got.alpha_written = out_if.alpha_written;
      sb.check_pixel(got);
    end
  end

  function automatic pixel_hsv_t mk_pixel(int hue, int bri, int sat, int alpha);
    pixel_hsv_t px;
    px.hue = hue[HUE_W-1:0];
    px.brightness = bri[LEVEL_W-1:0];
    px.saturation = sat[LEVEL_W-1:0];
    px.alpha = alpha[CHAN_W-1:0];
    return px;
  endfunction

  function automatic pixel_hsv_t rand_pixel();
    pixel_hsv_t px;
    px.hue = HUE_W'($urandom);
    case ($urandom_range(9))
      0: px.brightness = LEVEL_W'($urandom);
      1: px.brightness = '0;
      2: px.brightness = LEVEL_W'(ONE);
      3: px.brightness = -$signed(LEVEL_W'($urandom_range(1, 131072)));
      default: px.brightness = LEVEL_W'($urandom_range(1, 32'(ONE)));
    endcase
    case ($urandom_range(9))
      0: px.saturation = LEVEL_W'($urandom);
      1: px.saturation = LEVEL_W'(ONE);
      2: px.saturation = '0;
      3: px.saturation = LEVEL_W'($urandom_range(32'(ONE), 131071));
      default: px.saturation = LEVEL_W'($urandom_range(0, 32'(ONE - 1)));
    endcase
    px.alpha = CHAN_W'($urandom);
    return px;
  endfunction

  task automatic drive_pixel(pixel_hsv_t px);
    @(negedge clk);
    while (in_gaps && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.hue <= px.hue;
    in_if.brightness <= px.brightness;
    in_if.saturation <= px.saturation;
    in_if.alpha <= px.alpha;
    do @(posedge clk); while (!in_if.ready);
    sb.note_pixel(px);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic drive_random(int n);
    for (int k = 0; k < n; k++) drive_pixel(rand_pixel());
  endtask

  initial begin
    pixel_hsv_t corner_q[$];
    sb = new();
    rst_n = 1'b0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    hold_left = 0;
    in_if.valid = 1'b0;
    in_if.hue = '0;
    in_if.brightness = '0;
    in_if.saturation = '0;
    in_if.alpha = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    corner_q.push_back(mk_pixel(0, 65536, 0, 65536));
    corner_q.push_back(mk_pixel(-524288, 131071, -131072, 131071));
    corner_q.push_back(mk_pixel(524287, 65535, 1, 1));
    corner_q.push_back(mk_pixel(10923, 50000, 1000, 777));
    corner_q.push_back(mk_pixel(21846, 65536, 20000, 4096));
    corner_q.push_back(mk_pixel(32768, 40000, 0, 65536));
    corner_q.push_back(mk_pixel(43691, 65536, 30000, 12345));
    corner_q.push_back(mk_pixel(54614, 30000, 65535, 99));
    corner_q.push_back(mk_pixel(65535, 65536, 0, 0));
    corner_q.push_back(mk_pixel(-1, 60000, 100, 65535));
    corner_q.push_back(mk_pixel(65536, 65536, 0, 3));
    corner_q.push_back(mk_pixel(-65536, 65536, 0, 5));
    corner_q.push_back(mk_pixel(12000, 0, 0, 65536));
    corner_q.push_back(mk_pixel(12000, -131072, 5000, 131071));
    corner_q.push_back(mk_pixel(30000, 40000, 65536, 65536));
    corner_q.push_back(mk_pixel(30000, 131071, 131071, 1));
    corner_q.push_back(mk_pixel(50000, 65537, 65537, 7));
    corner_q.push_back(mk_pixel(50000, 1, -1, 131071));
    corner_q.push_back(mk_pixel(20000, 65536, -131072, 86000));
    corner_q.push_back(mk_pixel(-524287, 131071, 65535, 131071));
    foreach (corner_q[k]) drive_pixel(corner_q[k]);

    drive_random(300);

    in_gaps = 1'b0;
    out_gaps = 1'b0;
    drive_random(150);

    hold_left = HOLD_CYCLES;
    drive_random(100);
    wait_drained();

    in_gaps = 1'b1;
    out_gaps = 1'b1;
    drive_random(200);

    wait_drained();
    repeat (12) @(posedge clk);

    $display("summary: %0d pixels checked, %0d black, %0d grey, %0d mismatches",
             sb.checked, sb.black_cnt, sb.grey_cnt, sb.mismatches);
    $display("summary: hue sectors %0d/%0d/%0d/%0d/%0d/%0d, output held off %0d cycles once",
             sb.sector_cnt[0], sb.sector_cnt[1], sb.sector_cnt[2], sb.sector_cnt[3],
             sb.sector_cnt[4], sb.sector_cnt[5], HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
